>>> rtl/core/knn1d_pkg.sv
// Shared constants and types for the 1-D k-nearest-neighbor range core.
package knn1d_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 32;

  localparam int CFG_W    = 7;
  localparam int WIDX_W   = 6;
  localparam int VALUE_W  = 32;
  localparam int K_W      = 7;
  localparam int START_W  = 7;
  localparam int END_W    = 8;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SETTLE,
    S_PICK,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/knn1d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module knn1d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/knn1d_cell.sv
// Insertion-sort cell: keeps the smallest distance seen, passes the larger one on.
module knn1d_cell #(
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          in_vld,
  input  logic [DW-1:0] in_dist,
  output logic          out_vld,
  output logic [DW-1:0] out_dist,
  output logic [DW-1:0] held
);

  logic          held_vld_r;
  logic [DW-1:0] held_r;
  logic          out_vld_r;
  logic [DW-1:0] out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      held_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= in_vld && held_vld_r;
      if (in_vld) begin
        if (!held_vld_r) begin
          held_vld_r <= 1'b1;
          held_r     <= in_dist;
        end else if (in_dist < held_r) begin
          // keep the smaller one, push the old value down the chain
          held_r     <= in_dist;
          out_dist_r <= held_r;
        end else begin
          out_dist_r <= in_dist;
        end
      end
    end
  end

  assign out_vld  = out_vld_r;
  assign out_dist = out_dist_r;
  assign held     = held_r;

endmodule

>>> rtl/core/knn_symmetric_range_1d_core.sv
// Top level: a query reads the point store once per cycle to stream distances
// into a chain of sorting cells, lets the chain settle, and then makes a second
// pass over the store to find both bounds. A query with a bad count skips these
// steps and goes straight to the result. Writes go straight into the store.
module knn_symmetric_range_1d_core #(
  parameter int MAX_POINTS = knn1d_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = knn1d_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [knn1d_pkg::CFG_W-1:0]      cfg_wr_data,  // num_points
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // write_index, write_value, query_point, neighbor_count, zero pad
  input  logic [knn1d_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,     // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // range_start, range_end, zero pad
  output logic [knn1d_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                             out_tuser     // bad_count
);
  import knn1d_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = CNT_W + 1;
  localparam int DW    = COORD_BITS + 1;
  localparam int BW    = COORD_BITS + 2;

  // input fields
  logic [WIDX_W-1:0]  f_widx;
  logic [VALUE_W-1:0] f_wval;
  logic [VALUE_W-1:0] f_qpt;
  logic [K_W-1:0]     f_k;
  assign f_widx = in_tdata[5:0];
  assign f_wval = in_tdata[37:6];
  assign f_qpt  = in_tdata[69:38];
  assign f_k    = in_tdata[76:70];

  // take the low COORD_BITS bits; the sign comes from bit COORD_BITS-1
  logic [COORD_BITS+VALUE_W-1:0] wval_ext, qpt_ext;
  assign wval_ext = {{COORD_BITS{1'b0}}, f_wval};
  assign qpt_ext  = {{COORD_BITS{1'b0}}, f_qpt};

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       k_r;
  logic [COORD_BITS-1:0]  q_r;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   pipe_vld_r;
  logic [CNT_W-1:0]       pipe_idx_r;
  logic signed [BW-1:0]   lo_r, hi_r;
  logic [CNT_W-1:0]       start_r;
  logic signed [CNT_W:0]  end_r;
  logic                   found_r;
  logic                   bad_r;
  logic                   out_vld_r;
  logic [START_W-1:0]     out_start_r;
  logic [END_W-1:0]       out_end_r;
  logic                   out_bad_r;

  logic in_acc, is_query, q_bad, chain_clr, rd_issue, out_free;
  assign in_acc   = in_tvalid && in_tready;
  assign is_query = (in_tuser == REQ_QUERY);
  assign q_bad    = (f_k == '0) || (int'(f_k) > int'(n_r));
  assign out_free = !out_vld_r || out_tready;

  // point store
  logic                  ram_we;
  logic [WIDX_W+AW-1:0]  widx_ext;
  logic [AW-1:0]         ram_raddr;
  logic [COORD_BITS-1:0] ram_q;
  assign widx_ext  = (WIDX_W + AW)'(f_widx);
  assign ram_we    = in_acc && (in_tuser == REQ_WRITE) && (int'(f_widx) < MAX_POINTS);
  assign ram_raddr = cnt_r[AW-1:0];

  knn1d_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_ext[AW-1:0]),
    .wdata (wval_ext[COORD_BITS-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // distance into the sorting chain
  logic signed [DW-1:0] diff;
  logic [DW-1:0]        abs_diff;
  assign diff = signed'({ram_q[COORD_BITS-1], ram_q}) - signed'({q_r[COORD_BITS-1], q_r});
  assign abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);

  logic          c_vld  [MAX_POINTS+1];
  logic [DW-1:0] c_dist [MAX_POINTS+1];
  logic [DW-1:0] held   [MAX_POINTS];

  assign chain_clr = in_acc && is_query;
  assign c_vld[0]  = pipe_vld_r && (state_r == S_LOAD);
  assign c_dist[0] = abs_diff;

  for (genvar j = 0; j < MAX_POINTS; j++) begin : g_cell
    knn1d_cell #(.DW(DW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clr      (chain_clr),
      .in_vld   (c_vld[j]),
      .in_dist  (c_dist[j]),
      .out_vld  (c_vld[j+1]),
      .out_dist (c_dist[j+1]),
      .held     (held[j])
    );
  end

  // k-th smallest distance and the bounds
  logic [CNT_W-1:0]     k_m1;
  logic [DW-1:0]        d_sel;
  logic signed [BW-1:0] q_ext, d_ext, p_ext;
  assign k_m1  = k_r - 1'b1;
  assign d_sel = held[k_m1[AW-1:0]];
  assign q_ext = BW'(signed'(q_r));
  assign d_ext = signed'(BW'(d_sel));
  assign p_ext = BW'(signed'(ram_q));

  logic [CW-1:0] n_ext;
  assign n_ext    = CW'(n_r);
  assign rd_issue = ((state_r == S_LOAD) || (state_r == S_SCAN)) && (cnt_r < n_ext);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_acc && is_query) begin
          state_nxt = q_bad ? S_DONE : S_LOAD;
        end
      end
      S_LOAD: begin
        if (cnt_r == n_ext) begin
          state_nxt = S_SETTLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SETTLE: begin
        if (cnt_r == n_ext + 1'b1) begin
          state_nxt = S_PICK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PICK: begin
        state_nxt = S_SCAN;
        cnt_nxt   = '0;
      end
      S_SCAN: begin
        if (cnt_r == n_ext) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      n_r       <= CNT_W'(1);
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        n_r <= (int'(cfg_wr_data) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(cfg_wr_data);
      end
      if (state_r == S_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    pipe_vld_r <= rd_issue;
    pipe_idx_r <= cnt_r[CNT_W-1:0];
    if (in_acc && is_query) begin
      q_r     <= qpt_ext[COORD_BITS-1:0];
      k_r     <= CNT_W'(f_k);
      bad_r   <= q_bad;
      start_r <= n_r;
      end_r   <= '1;
      found_r <= 1'b0;
    end
    if (state_r == S_PICK) begin
      lo_r <= q_ext - d_ext;
      hi_r <= q_ext + d_ext;
    end
    if (state_r == S_SCAN && pipe_vld_r) begin
      if (!found_r && p_ext >= lo_r) begin
        start_r <= pipe_idx_r;
        found_r <= 1'b1;
      end
      if (p_ext <= hi_r) begin
        end_r <= signed'({1'b0, pipe_idx_r + 1'b1});
      end
    end
    if (state_r == S_DONE && out_free) begin
      out_start_r <= START_W'(start_r);
      out_end_r   <= END_W'(end_r);
      out_bad_r   <= bad_r;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_end_r, out_start_r};
  assign out_tuser  = out_bad_r;

endmodule

>>> rtl/core/knn1d_checker.sv
// Port-level checks for the 1-D k-nearest-neighbor range core, bound to the top.
module knn1d_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [knn1d_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import knn1d_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_bad_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[14:7] == 8'hFF)
    else $error("bad count without empty range end");

  // a good query always covers at least one point
  a_good_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[14] == 1'b0 && out_tdata[14:7] != 8'h00)
    else $error("good query returned empty range end");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == REQ_QUERY |=> !in_tready)
    else $error("input taken while a query is in flight");

endmodule

bind knn_symmetric_range_1d_core knn1d_checker u_knn1d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> dv/knn_symmetric_range_1d_core_tb.sv
// Self-checking testbench for the 1-D k-nearest-neighbor symmetric range core.
module knn_symmetric_range_1d_core_tb;
  import knn1d_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;

  typedef struct packed {
    logic                 req;
    logic [WIDX_W-1:0]    widx;
    logic [VALUE_W-1:0]   wval;
    logic [VALUE_W-1:0]   qpt;
    logic [K_W-1:0]       k;
  } req_item_t;

  typedef struct packed {
    logic [START_W-1:0] rstart;
    logic [END_W-1:0]   rend;
    logic               bad;
  } range_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  knn_symmetric_range_1d_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  // predictor state
  logic signed [VALUE_W-1:0] pt_mirror [NPTS];
  int unsigned active_pts = 1;

  req_item_t  pending_reqs[$];
  range_res_t expected_ranges[$];
  int mismatches = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  bit hold_out = 1'b0;
  bit stim_done = 1'b0;
  longint cycles = 0;

  function automatic range_res_t predict_range(req_item_t it);
    range_res_t r;
    longint q, d, lo, hi, di, dj;
    int less, lesseq;
    bit found;
    r.rstart = START_W'(active_pts);
    r.rend = '1;
    r.bad = 1'b0;
    if (it.k == 0 || it.k > active_pts) begin
      r.bad = 1'b1;
      return r;
    end
    q = longint'($signed(it.qpt));
    d = 0;
    found = 1'b0;
    for (int i = 0; i < active_pts && !found; i++) begin
      di = longint'(pt_mirror[i]) - q;
      if (di < 0) di = -di;
      less = 0;
      lesseq = 0;
      for (int j = 0; j < active_pts; j++) begin
        dj = longint'(pt_mirror[j]) - q;
        if (dj < 0) dj = -dj;
        if (dj < di) less++;
        if (dj <= di) lesseq++;
      end
      if (less < it.k && it.k <= lesseq) begin
        d = di;
        found = 1'b1;
      end
    end
    lo = q - d;
    hi = q + d;
    for (int i = 0; i < active_pts; i++)
      if (longint'(pt_mirror[i]) >= lo) begin
        r.rstart = START_W'(i);
        break;
      end
    for (int i = active_pts; i > 0; i--)
      if (longint'(pt_mirror[i-1]) <= hi) begin
        r.rend = END_W'(i);
        break;
      end
    return r;
  endfunction

  // driver: advance on acceptance, pick next item at the falling edge
  always @(negedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
    end
  end

  bit in_fire;
  always @(posedge clk) in_fire <= in_tvalid && in_tready && rst_n;

  always @(negedge clk) begin
    if (!(in_tvalid && !in_fire)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        req_item_t it;
        it = pending_reqs.pop_front();
        in_tdata <= {{(IN_DATA_W-77){1'b0}}, it.k, it.qpt, it.wval, it.widx};
        in_tuser <= it.req;
        in_tvalid <= 1'b1;
        // model the effect when the item is driven: store order matches stream order
        if (it.req == REQ_WRITE) pt_mirror[it.widx] = it.wval;
        else expected_ranges.push_back(predict_range(it));
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= !hold_out && ($urandom_range(99) >= out_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      range_res_t got, exp_r;
      got.rstart = out_tdata[START_W-1:0];
      got.rend = out_tdata[START_W +: END_W];
      got.bad = out_tuser;
      if (expected_ranges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_ranges.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  function automatic req_item_t mk_write(int idx, logic [31:0] v);
    req_item_t it;
    it = '0;
    it.req = REQ_WRITE;
    it.widx = idx[WIDX_W-1:0];
    it.wval = v;
    it.qpt = $urandom();
    it.k = K_W'($urandom());
    return it;
  endfunction

  function automatic req_item_t mk_query(logic [31:0] q, int k);
    req_item_t it;
    it.req = REQ_QUERY;
    it.widx = WIDX_W'($urandom());
    it.wval = $urandom();
    it.qpt = q;
    it.k = K_W'(k);
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(40)) - 20) <<< 16;
      2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_ranges.size() != 0)
      @(posedge clk);
    repeat (3 * NPTS + 20) @(posedge clk);
  endtask

  task automatic set_points(int n);
    @(negedge clk);
    cfg_wr_data <= CFG_W'(n);
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    active_pts = (n > NPTS) ? NPTS : n;
  endtask

  initial begin
    int n;
    int sizes[6] = '{64, 1, 7, 3, 64, 20};
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // fill the whole store so no unwritten slot is ever read
    for (int i = 0; i < NPTS; i++) pending_reqs.push_back(mk_write(i, rand_coord()));
    pending_reqs.push_back(mk_query(32'h0, 1));
    pending_reqs.push_back(mk_query(32'h0, 0));
    pending_reqs.push_back(mk_query(32'h0, 2));
    wait_drained();
    set_points(127);  // saturates to the store depth
    pending_reqs.push_back(mk_write(0, 32'h7fffffff));
    pending_reqs.push_back(mk_write(1, 32'h80000000));
    pending_reqs.push_back(mk_query(32'h80000000, 64));
    pending_reqs.push_back(mk_query(32'h7fffffff, 1));
    pending_reqs.push_back(mk_query(32'h7fffffff, 2));
    pending_reqs.push_back(mk_query(32'h80000000, 65));
    pending_reqs.push_back(mk_query(32'h12345678, 127));
    wait_drained();
    set_points(0);
    pending_reqs.push_back(mk_query(32'h0, 0));
    pending_reqs.push_back(mk_query(32'h0, 1));
    wait_drained();
    for (int ph = 0; ph < 6; ph++) begin
      in_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 61 : 0;
      out_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 7 : 0;
      set_points(sizes[ph]);
      n = sizes[ph];
      for (int j = 0; j < 250; j++) begin
        if ($urandom_range(2) == 0)
          pending_reqs.push_back(mk_write($urandom_range(NPTS - 1), rand_coord()));
        else
          pending_reqs.push_back(mk_query(
              $urandom_range(1) ? rand_coord() : pt_pick(), $urandom_range(n + 1)));
      end
      if (ph == 2) begin
        hold_out = 1'b1;
        repeat (2000) @(posedge clk);
        hold_out = 1'b0;
      end
      wait_drained();
    end
    stim_done = 1'b1;
  end

  // query near a stored value; the point is picked from the mirror when the query is queued
  function automatic logic [31:0] pt_pick();
    return pt_mirror[$urandom_range(NPTS - 1)] + 32'($urandom_range(2)) - 32'd1;
  endfunction

  always @(posedge clk) begin
    if (stim_done) begin
      if (mismatches == 0 && expected_ranges.size() == 0)
        $display("knn_symmetric_range_1d_core_tb passed");
      else
        $display("knn_symmetric_range_1d_core_tb failed");
      $finish;
    end else if (cycles > 2000000) begin
      $display("knn_symmetric_range_1d_core_tb failed");
      $finish;
    end
  end

endmodule
